// ===== rtl/ccpc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ccpc_pkg;

	// Field and register widths
	localparam int DATA_W    = 13;
	localparam int OUT_W     = 12;
	localparam int MOD_W     = 12;
	localparam int BPC_W     = 4;
	localparam int DIR_W     = 2;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 12;
	localparam int BYTE_W    = 8;

	// Bit buffer
	localparam int BUF_W = 18;
	localparam int CNT_W = 5;

	// Smallest coefficient width
	localparam int D_MIN = 8;

	typedef enum logic [DIR_W-1:0] {
		DIR_COMPRESS   = 2'd0,
		DIR_DECOMPRESS = 2'd1,
		DIR_RAW        = 2'd2,
		DIR_NONE       = 2'd3
	} dir_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DIRECTION = 2'd0,
		CFG_BITS      = 2'd1,
		CFG_MODULUS   = 2'd2,
		CFG_UNUSED    = 2'd3
	} cfg_idx_t;

	localparam dir_t             DIR_RESET = DIR_COMPRESS;
	localparam logic [BPC_W-1:0] BPC_RESET = 4'd10;
	localparam logic [MOD_W-1:0] MOD_RESET = 12'd3329;

endpackage

`default_nettype wire

// ===== rtl/coeff_compress_pack_codec_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Coefficient compress/pack and unpack/decompress codec.
// Input channel (item_valid/item_stall): data_in and first_of_vector; a
// transaction completes when item_valid is high and item_stall is low.
// Output channel (res_valid/res_stall): out_value and last_of_run; each input
// item gives zero, one or two result transactions, last_of_run marks the final.
// Config port: cfg_we/cfg_index/cfg_wdata; the user must write it only while
// the block is idle, which the block does not enforce. One item is processed
// at a time; item_stall is high until its last result sits in the output
// register, so the next item is taken while it waits. Compress: each item
// runs the serial divider (DATA_W + MAX_D + 1 steps) when the modulus is
// nonzero, then one push and one pop per byte. Raw unpack: one push, then
// one pop per value. Decompress: each popped value runs the serial multiplier.
// Reset clears the bit buffer and output valid flag and sets config to its defaults.
// When the receiver stalls, the result is held and processing waits for the
// output register to free up; no result is dropped.
module coeff_compress_pack_codec_unit #(
	parameter int MAX_D = 11
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,

	input  wire logic                                item_valid,
	output logic                                     item_stall,
	input  wire logic signed [ccpc_pkg::DATA_W-1:0]  data_in,
	input  wire logic                                first_of_vector,

	output logic                                     res_valid,
	input  wire logic                                res_stall,
	output logic [ccpc_pkg::OUT_W-1:0]               out_value,
	output logic                                     last_of_run,

	input  wire logic                                cfg_we,
	input  wire logic [ccpc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [ccpc_pkg::CFG_W-1:0]          cfg_wdata
);
	import ccpc_pkg::*;

	localparam int NUM_W = DATA_W + MAX_D + 1;
	localparam int PW    = MAX_D + MOD_W;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_DIV  = 5'b00010,
		ST_PUSH = 5'b00100,
		ST_POP  = 5'b01000,
		ST_MUL  = 5'b10000
	} state_t;

	state_t             state_q;
	dir_t               dir_q;
	logic [BPC_W-1:0]   bpc_q;
	logic [MOD_W-1:0]   mod_q;
	logic [BUF_W-1:0]   buf_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [1:0]         n_q;
	logic [MAX_D-1:0]   push_val_q;
	logic               last_pend_q;
	logic               res_valid_q;
	logic [OUT_W-1:0]   res_value_q;
	logic               res_last_q;

	logic               accept;
	logic [BPC_W-1:0]   d_eff;
	logic [MAX_D-1:0]   mask_d;
	logic [BPC_W-1:0]   need;
	logic [BPC_W-1:0]   push_w;
	logic [DATA_W-1:0]  raw;
	logic [DATA_W-1:0]  u;
	logic [NUM_W-1:0]   num;

	logic [BUF_W-1:0]   shifted;
	logic [BUF_W-1:0]   buf_pushed;
	logic [CNT_W-1:0]   cnt_sum;
	logic [CNT_W-1:0]   cnt_pushed;

	logic               can_pop;
	logic [BUF_W-1:0]   pop_bits;
	logic [MAX_D-1:0]   pop_t;
	logic [CNT_W-1:0]   cnt_left;
	logic               last_now;
	logic               out_free;

	logic               div_start;
	logic               div_busy;
	logic [MAX_D-1:0]   div_quo;
	logic               mul_start;
	logic               mul_busy;
	logic [PW-1:0]      mul_prod;
	logic [PW:0]        rnd_sum;
	logic [PW:0]        decomp_v;

	logic               out_load;
	logic [OUT_W-1:0]   out_load_value;
	logic               out_load_last;

	assign accept = item_valid && !item_stall;
	assign item_stall = (state_q != ST_IDLE);

	// Width clamped to D_MIN..MAX_D
	always_comb begin
		if (bpc_q < BPC_W'(D_MIN))
			d_eff = BPC_W'(D_MIN);
		else if (bpc_q > BPC_W'(MAX_D))
			d_eff = BPC_W'(MAX_D);
		else
			d_eff = bpc_q;
	end

	assign mask_d = ~({MAX_D{1'b1}} << d_eff);
	assign need   = (dir_q == DIR_COMPRESS) ? BPC_W'(BYTE_W) : d_eff;
	assign push_w = (dir_q == DIR_COMPRESS) ? d_eff : BPC_W'(BYTE_W);

	// Negative coefficient gets q added, wrapping at 13 bits
	assign raw = $unsigned(data_in);
	assign u   = raw[DATA_W-1] ? (raw + DATA_W'(mod_q)) : raw;
	assign num = (NUM_W'(u) << d_eff) + NUM_W'(mod_q >> 1);

	// Push into bit buffer; bits beyond the top are lost
	assign shifted    = BUF_W'(push_val_q) << cnt_q;
	assign buf_pushed = (cnt_q < CNT_W'(BUF_W)) ? (buf_q | shifted) : buf_q;
	assign cnt_sum    = cnt_q + CNT_W'(push_w);
	assign cnt_pushed = (cnt_sum > CNT_W'(BUF_W)) ? CNT_W'(BUF_W) : cnt_sum;

	// Pop side
	assign can_pop  = (n_q < 2'd2) && (cnt_q >= CNT_W'(need));
	assign pop_bits = buf_q & ~({BUF_W{1'b1}} << need);
	assign pop_t    = pop_bits[MAX_D-1:0];
	assign cnt_left = cnt_q - CNT_W'(need);
	assign last_now = !((n_q == 2'd0) && (cnt_left >= CNT_W'(need)));
	assign out_free = !res_valid_q || !res_stall;

	assign div_start = (state_q == ST_IDLE) && accept && (dir_q == DIR_COMPRESS)
		&& (mod_q != '0);
	assign mul_start = (state_q == ST_POP) && can_pop && out_free
		&& (dir_q == DIR_DECOMPRESS);

	assign rnd_sum  = {1'b0, mul_prod} + ((PW+1)'(1) << (d_eff - 1'b1));
	assign decomp_v = rnd_sum >> d_eff;

	ccpc_div #(
		.MAX_D(MAX_D)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.num     (num),
		.divisor (mod_q),
		.busy    (div_busy),
		.quotient(div_quo)
	);

	ccpc_mul #(
		.MAX_D(MAX_D)
	) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.mplier (pop_t),
		.mcand  (mod_q),
		.busy   (mul_busy),
		.product(mul_prod)
	);

	// Output register load
	always_comb begin
		out_load       = 1'b0;
		out_load_value = OUT_W'(pop_t);
		out_load_last  = last_now;
		unique case (state_q)
			ST_POP: begin
				if (can_pop && out_free && (dir_q != DIR_DECOMPRESS))
					out_load = 1'b1;
			end
			ST_MUL: begin
				out_load_value = decomp_v[OUT_W-1:0];
				out_load_last  = last_pend_q;
				if (!mul_busy && out_free)
					out_load = 1'b1;
			end
			ST_IDLE, ST_DIV, ST_PUSH: begin
				out_load = 1'b0;
			end
			default: begin
				out_load = 1'b0;
			end
		endcase
	end

	// Control, config and bit buffer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			dir_q   <= DIR_RESET;
			bpc_q   <= BPC_RESET;
			mod_q   <= MOD_RESET;
			buf_q   <= '0;
			cnt_q   <= '0;
			n_q     <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx_t'(cfg_index))
					CFG_DIRECTION: dir_q <= dir_t'(cfg_wdata[DIR_W-1:0]);
					CFG_BITS:      bpc_q <= cfg_wdata[BPC_W-1:0];
					CFG_MODULUS:   mod_q <= cfg_wdata[MOD_W-1:0];
					CFG_UNUSED:    ;
					default:       ;
				endcase
			end

			unique case (state_q)
				ST_IDLE: begin
					if (accept && (dir_q != DIR_NONE)) begin
						if (first_of_vector) begin
							buf_q <= '0;
							cnt_q <= '0;
						end
						n_q <= '0;
						if ((dir_q == DIR_COMPRESS) && (mod_q != '0))
							state_q <= ST_DIV;
						else
							state_q <= ST_PUSH;
					end
				end
				ST_DIV: begin
					if (!div_busy)
						state_q <= ST_PUSH;
				end
				ST_PUSH: begin
					buf_q   <= buf_pushed;
					cnt_q   <= cnt_pushed;
					state_q <= ST_POP;
				end
				ST_POP: begin
					if (!can_pop) begin
						state_q <= ST_IDLE;
					end else if (out_free) begin
						buf_q <= buf_q >> need;
						cnt_q <= cnt_left;
						n_q   <= n_q + 1'b1;
						if (dir_q == DIR_DECOMPRESS)
							state_q <= ST_MUL;
						else if (last_now)
							state_q <= ST_IDLE;
					end
				end
				ST_MUL: begin
					if (out_load)
						state_q <= last_pend_q ? ST_IDLE : ST_POP;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Value to push: compress quotient, all ones for zero modulus, or byte
	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && accept) begin
			if (dir_q == DIR_COMPRESS)
				push_val_q <= mask_d;
			else
				push_val_q <= MAX_D'(raw[BYTE_W-1:0]);
		end else if ((state_q == ST_DIV) && !div_busy) begin
			push_val_q <= div_quo & mask_d;
		end
		if (mul_start)
			last_pend_q <= last_now;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (out_load)
			res_valid_q <= 1'b1;
		else if (res_valid_q && !res_stall)
			res_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			res_value_q <= out_load_value;
			res_last_q  <= out_load_last;
		end
	end

	assign res_valid   = res_valid_q;
	assign out_value   = res_value_q;
	assign last_of_run = res_last_q;

endmodule

`default_nettype wire

// ===== rtl/ccpc_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per cycle, MSB first.
// Only the low MAX_D quotient bits are kept.
module ccpc_div #(
	parameter int MAX_D = 11
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [ccpc_pkg::DATA_W+MAX_D:0] num,
	input  wire logic [ccpc_pkg::MOD_W-1:0]    divisor,
	output logic                               busy,
	output logic [MAX_D-1:0]                   quotient
);
	import ccpc_pkg::*;

	localparam int NUM_W  = DATA_W + MAX_D + 1;
	localparam int STEP_W = $clog2(NUM_W);

	logic [NUM_W-1:0]  num_q;
	logic [MOD_W-1:0]  rem_q;
	logic [MOD_W-1:0]  div_q;
	logic [MAX_D-1:0]  quo_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;

	logic [MOD_W:0]    trial;
	logic              ge;
	logic [MOD_W:0]    diff;

	assign trial = {rem_q, num_q[NUM_W-1]};
	assign ge    = trial >= {1'b0, div_q};
	assign diff  = trial - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= STEP_W'(NUM_W - 1);
		end else if (busy_q) begin
			step_q <= step_q - 1'b1;
			if (step_q == '0)
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			div_q <= divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[NUM_W-2:0], 1'b0};
			rem_q <= ge ? diff[MOD_W-1:0] : trial[MOD_W-1:0];
			quo_q <= {quo_q[MAX_D-2:0], ge};
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

// ===== rtl/ccpc_mul.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Shift-add multiplier, one multiplier bit per cycle, LSB first.
module ccpc_mul #(
	parameter int MAX_D = 11
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	input  wire logic [MAX_D-1:0]               mplier,
	input  wire logic [ccpc_pkg::MOD_W-1:0]     mcand,
	output logic                                busy,
	output logic [MAX_D+ccpc_pkg::MOD_W-1:0]    product
);
	import ccpc_pkg::*;

	localparam int PW     = MAX_D + MOD_W;
	localparam int STEP_W = $clog2(MAX_D);

	logic [PW-1:0]     prod_q;
	logic [MOD_W-1:0]  mcand_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;

	logic [MOD_W:0]    sum;

	assign sum = {1'b0, prod_q[PW-1:MAX_D]} + (prod_q[0] ? {1'b0, mcand_q} : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= STEP_W'(MAX_D - 1);
		end else if (busy_q) begin
			step_q <= step_q - 1'b1;
			if (step_q == '0)
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			prod_q  <= {{MOD_W{1'b0}}, mplier};
			mcand_q <= mcand;
		end else if (busy_q) begin
			prod_q <= {sum, prod_q[MAX_D-1:1]};
		end
	end

	assign busy    = busy_q;
	assign product = prod_q;

endmodule

`default_nettype wire
